// ===== design/cba_pkg.sv =====
// Shared types and codes for the contiguous block allocator.
// No dependencies; compile first.
package cba_pkg;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Request classification made at accept time
  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_FREE  = 2'd1,
    K_READ  = 2'd2,
    K_BAD   = 2'd3
  } kind_t;

  // Datapath operation selected by the controller each cycle
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_ACCEPT     = 3'd2,
    OP_ALLOC_SCAN = 3'd3,
    OP_MARK       = 3'd4,
    OP_FREE_SCAN  = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  clear_last;
    logic  alloc_hit;
    logic  alloc_miss;
    logic  mark_last;
    logic  free_end;
    logic  read_done;
  } dp_stat_t;

endpackage

// ===== design/cba_if.sv =====
// Request and response channel interfaces for the block allocator.
// Depends on nothing; compile after cba_pkg.
interface cba_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] request_size;
  logic [4:0] block_index;

  modport source (output valid, output cmd, output request_size, output block_index,
                  input ready);
  modport sink   (input valid, input cmd, input request_size, input block_index,
                  output ready);
endinterface

interface cba_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] first_block;
  logic [4:0] last_block;
  logic       entry_free;
  logic [4:0] entry_owner;

  modport source (output valid, output status, output first_block, output last_block,
                  output entry_free, output entry_owner, input ready);
  modport sink   (input valid, input status, input first_block, input last_block,
                  input entry_free, input entry_owner, output ready);
endinterface

// ===== design/cba_ctrl.sv =====
// Controller state machine for the block allocator.
// Depends on cba_pkg; drives the datapath through dp_cmd_t.
module cba_ctrl import cba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ALLOC = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          case (stat.kind)
            K_ALLOC: state_next = S_ALLOC;
            K_FREE:  state_next = S_FREE;
            K_READ:  state_next = S_READ;
            default: state_next = S_RESP;
          endcase
        end
      end
      S_ALLOC: begin
        cmd.op = OP_ALLOC_SCAN;
        if (stat.alloc_hit) state_next = S_MARK;
        else if (stat.alloc_miss) state_next = S_RESP;
      end
      S_MARK: begin
        cmd.op = OP_MARK;
        if (stat.mark_last) state_next = S_RESP;
      end
      S_FREE: begin
        cmd.op = OP_FREE_SCAN;
        if (stat.free_end) state_next = S_RESP;
      end
      S_READ: begin
        cmd.op = OP_READ;
        if (stat.read_done) state_next = S_RESP;
      end
      S_RESP: begin
        // hand the pending result to the output register once it is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/cba_dp.sv =====
// Datapath for the block allocator: block table memory, scan pointer,
// run tracking, pending result and output word register. Depends on cba_pkg.
module cba_dp import cba_pkg::*; #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  input  logic [1:0] req_cmd,
  input  logic [5:0] req_size,
  input  logic [4:0] req_index,
  output logic [1:0] rsp_status,
  output logic [4:0] rsp_first,
  output logic [4:0] rsp_last,
  output logic       rsp_efree,
  output logic [4:0] rsp_eowner
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = (AW + 1 > 6) ? AW + 1 : 6;
  localparam logic [AW:0]   NB_P     = (AW + 1)'(NUM_BLOCKS);
  localparam logic [CW-1:0] NB_C     = CW'(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

  typedef struct packed {
    logic          used;
    logic [AW-1:0] owner;
  } entry_t;

  entry_t mem [NUM_BLOCKS];
  entry_t rdata;
  entry_t wdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic          issue;

  logic [CW-1:0] idx_ext, size_ext;
  kind_t         kind;

  logic [CW-1:0] size_r;
  logic [AW-1:0] idx_r;
  logic [AW:0]   ptr;
  logic          dv;
  logic [AW-1:0] didx;
  logic [CW-1:0] count;
  logic [AW-1:0] start;

  status_t       p_st;
  logic [AW-1:0] p_first, p_last, p_eowner;
  logic          p_efree;

  logic [CW-1:0] cnt_inc;
  logic [AW-1:0] hit_start;
  logic          own_ok;
  logic          alloc_hit, alloc_miss, free_end;
  logic [CW-1:0] pf_w, pl_w, po_w;

  // request decode
  assign idx_ext  = CW'(req_index);
  assign size_ext = CW'(req_size);

  always_comb begin
    case (req_cmd)
      CMD_ALLOC: kind = (req_size == 6'd0) ? K_BAD : K_ALLOC;
      CMD_FREE:  kind = (idx_ext < NB_C) ? K_FREE : K_BAD;
      CMD_READ:  kind = (idx_ext < NB_C) ? K_READ : K_BAD;
      default:   kind = K_BAD;
    endcase
  end

  // scan evaluation on the entry read last cycle (didx)
  assign cnt_inc   = count + CW'(1);
  assign hit_start = (count == '0) ? didx : start;
  assign own_ok    = rdata.used && (rdata.owner == idx_r);
  assign alloc_hit = (cmd.op == OP_ALLOC_SCAN) && dv && !rdata.used && (cnt_inc == size_r);
  assign alloc_miss = (cmd.op == OP_ALLOC_SCAN) && dv && !alloc_hit && (didx == LAST_IDX);
  assign free_end  = (cmd.op == OP_FREE_SCAN) && dv && (!own_ok || didx == LAST_IDX);

  assign stat.kind       = kind;
  assign stat.clear_last = (cmd.op == OP_CLEAR) && (ptr[AW-1:0] == LAST_IDX);
  assign stat.alloc_hit  = alloc_hit;
  assign stat.alloc_miss = alloc_miss;
  assign stat.mark_last  = (cmd.op == OP_MARK) && (count == CW'(1));
  assign stat.free_end   = free_end;
  assign stat.read_done  = (cmd.op == OP_READ) && dv;

  assign issue = ((cmd.op == OP_ALLOC_SCAN) || (cmd.op == OP_FREE_SCAN) ||
                  (cmd.op == OP_READ)) && (ptr < NB_P);

  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = '0;
    case (cmd.op)
      OP_CLEAR: we = 1'b1;
      OP_MARK: begin
        we    = 1'b1;
        wdata = '{used: 1'b1, owner: start};
      end
      OP_FREE_SCAN: begin
        if (dv && own_ok) begin
          we    = 1'b1;
          waddr = didx;
        end
      end
      default: we = 1'b0;
    endcase
  end

  // block table
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (issue) rdata <= mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      dv  <= 1'b0;
    end else begin
      dv <= issue;
      case (cmd.op)
        OP_CLEAR, OP_MARK: ptr <= ptr + (AW + 1)'(1);
        OP_ACCEPT: ptr <= (kind == K_ALLOC) ? '0 : idx_ext[AW:0];
        OP_ALLOC_SCAN, OP_FREE_SCAN, OP_READ: begin
          if (alloc_hit) ptr <= {1'b0, hit_start};
          else if (issue) ptr <= ptr + (AW + 1)'(1);
        end
        default: ptr <= ptr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    didx <= ptr[AW-1:0];
    case (cmd.op)
      OP_ACCEPT: begin
        size_r <= size_ext;
        idx_r  <= idx_ext[AW-1:0];
        count  <= '0;
        if (kind == K_BAD) begin
          p_st     <= ST_INVALID;
          p_first  <= '0;
          p_last   <= '0;
          p_efree  <= 1'b0;
          p_eowner <= '0;
        end
      end
      OP_ALLOC_SCAN: begin
        if (dv) begin
          if (!rdata.used) begin
            count <= cnt_inc;
            start <= hit_start;
          end else begin
            count <= '0;
          end
        end
        if (alloc_hit) begin
          p_st     <= ST_DONE;
          p_first  <= hit_start;
          p_last   <= didx;
          p_efree  <= 1'b0;
          p_eowner <= '0;
        end else if (alloc_miss) begin
          p_st     <= ST_NOSPACE;
          p_first  <= '0;
          p_last   <= '0;
          p_efree  <= 1'b0;
          p_eowner <= '0;
        end
      end
      OP_MARK: count <= count - CW'(1);
      OP_FREE_SCAN: begin
        if (dv && own_ok) begin
          count  <= cnt_inc;
          p_last <= didx;
        end
        if (free_end) begin
          p_efree  <= 1'b0;
          p_eowner <= '0;
          if (own_ok || count != '0) begin
            p_st    <= ST_DONE;
            p_first <= idx_r;
          end else begin
            // first entry is not a file start
            p_st    <= ST_INVALID;
            p_first <= '0;
            p_last  <= '0;
          end
        end
      end
      OP_READ: begin
        if (dv) begin
          p_st     <= ST_DONE;
          p_first  <= '0;
          p_last   <= '0;
          p_efree  <= !rdata.used;
          p_eowner <= rdata.used ? rdata.owner : '0;
        end
      end
      default: count <= count;
    endcase
  end

  // block numbers leave as 5 bits
  assign pf_w = CW'(p_first);
  assign pl_w = CW'(p_last);
  assign po_w = CW'(p_eowner);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_status <= p_st;
      rsp_first  <= pf_w[4:0];
      rsp_last   <= pl_w[4:0];
      rsp_efree  <= p_efree;
      rsp_eowner <= po_w[4:0];
    end
  end

endmodule

// ===== design/contiguous_block_allocator_core.sv =====
// Top level of the first-fit contiguous block allocator.
// Depends on cba_pkg, cba_if, cba_ctrl and cba_dp.
//
//   channel  dir  modport  word fields
//   req      in   sink     cmd, request_size, block_index
//   rsp      out  source   status, first_block, last_block, entry_free, entry_owner
//
// Allocate scans the table from block 0 with a registered read, then writes one entry
// per block marked; free walks the run from block_index and clears each entry owned by
// block_index; read fetches a single entry; an invalid request goes straight to the response.
// Reset (rst, synchronous) starts a clearing pass over the table; req.ready is low.
// A request is accepted while the previous result still waits in the output register.
module contiguous_block_allocator_core import cba_pkg::*; #(
  parameter int NUM_BLOCKS = 32
) (
  input logic    clk,
  input logic    rst,
  cba_req_if.sink   req,
  cba_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_cmd    (req.cmd),
    .req_size   (req.request_size),
    .req_index  (req.block_index),
    .rsp_status (rsp.status),
    .rsp_first  (rsp.first_block),
    .rsp_last   (rsp.last_block),
    .rsp_efree  (rsp.entry_free),
    .rsp_eowner (rsp.entry_owner)
  );

  // one request in flight: ready drops right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  // result register only loaded when empty or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp.valid || rsp.ready))
    else $error("pending result overwrote an untaken word");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req.ready)
    else $error("request taken before table clear");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == ST_DONE || rsp.status == ST_NOSPACE ||
                   rsp.status == ST_INVALID))
    else $error("illegal status code");

endmodule
